[rtl/core/http2_frame_deframer_defines.svh]
// Assertion macros for the HTTP/2 frame deframer.
`ifndef HTTP2_FRAME_DEFRAMER_DEFINES_SVH
`define HTTP2_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define H2FD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define H2FD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/h2fd_pkg.sv]
// Types, constants and the preface table of the HTTP/2 frame deframer.
`timescale 1ns / 1ps

package h2fd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 24;
    localparam int STREAM_W   = 31;
    localparam int PHASE_W    = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [PHASE_W-1:0] PH_PREFACE0 = 6'd0;
    localparam logic [PHASE_W-1:0] PH_HDR0     = 6'd24;
    localparam logic [PHASE_W-1:0] PH_HDR_LAST = 6'd32;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 6'd33;
    localparam logic [PHASE_W-1:0] PH_HALT     = 6'd34;

    localparam logic [3:0] HDR_LEN_HI  = 4'd0;
    localparam logic [3:0] HDR_LEN_MID = 4'd1;
    localparam logic [3:0] HDR_LEN_LO  = 4'd2;
    localparam logic [3:0] HDR_TYPE    = 4'd3;
    localparam logic [3:0] HDR_FLAGS   = 4'd4;
    localparam logic [3:0] HDR_SID3    = 4'd5;
    localparam logic [3:0] HDR_SID2    = 4'd6;
    localparam logic [3:0] HDR_SID1    = 4'd7;

    localparam logic [BYTE_W-1:0] TYPE_HEADERS     = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_SETTINGS    = 8'd4;
    localparam logic [BYTE_W-1:0] TYPE_CONT        = 8'd9;
    localparam int                FLAG_END_HEADERS = 2;
    localparam logic [BYTE_W-1:0] SID_TOP_MASK     = 8'h7f;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECT_PREFACE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_SIZE = 8'd1;
    localparam logic [LEN_W-1:0]     MAX_FRAME_RESET    = 24'd16384;

    typedef enum logic [2:0] {
        KIND_PREFACE  = 3'd0,
        KIND_HDR_BYTE = 3'd1,
        KIND_HDR_DONE = 3'd2,
        KIND_PAYLOAD  = 3'd3,
        KIND_ERROR    = 3'd4,
        KIND_HALTED   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_PREFACE      = 3'd1,
        ERR_FIRST_NOT_SET = 3'd2,
        ERR_CONT_EXPECT  = 3'd3,
        ERR_CONT_STREAM  = 3'd4,
        ERR_CONT_UNEXP   = 3'd5,
        ERR_SET_STREAM   = 3'd6,
        ERR_TOO_LARGE    = 3'd7
    } t_err;

    typedef struct packed {
        t_kind                kind;
        logic [BYTE_W-1:0]    data_byte;
        logic [LEN_W-1:0]     frame_length;
        logic [BYTE_W-1:0]    type_byte;
        logic [BYTE_W-1:0]    frame_flags;
        logic [STREAM_W-1:0]  stream_number;
        logic                 frame_end;
        t_err                 error_code;
    } t_result;

    // "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n"
    function automatic logic [BYTE_W-1:0] preface_byte(input logic [4:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            5'd0:  b = 8'h50;
            5'd1:  b = 8'h52;
            5'd2:  b = 8'h49;
            5'd3:  b = 8'h20;
            5'd4:  b = 8'h2a;
            5'd5:  b = 8'h20;
            5'd6:  b = 8'h48;
            5'd7:  b = 8'h54;
            5'd8:  b = 8'h54;
            5'd9:  b = 8'h50;
            5'd10: b = 8'h2f;
            5'd11: b = 8'h32;
            5'd12: b = 8'h2e;
            5'd13: b = 8'h30;
            5'd14: b = 8'h0d;
            5'd15: b = 8'h0a;
            5'd16: b = 8'h0d;
            5'd17: b = 8'h0a;
            5'd18: b = 8'h53;
            5'd19: b = 8'h4d;
            5'd20: b = 8'h0d;
            5'd21: b = 8'h0a;
            5'd22: b = 8'h0d;
            5'd23: b = 8'h0a;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/h2fd_byte_if.sv]
// Received-byte channel.
`timescale 1ns / 1ps

interface h2fd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [h2fd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/core/h2fd_result_if.sv]
// Result channel: one word per received byte.
`timescale 1ns / 1ps

interface h2fd_result_if;
    logic                            valid;
    logic                            ready;
    h2fd_pkg::t_kind                 kind;
    logic [h2fd_pkg::BYTE_W-1:0]     data_byte;
    logic [h2fd_pkg::LEN_W-1:0]      frame_length;
    logic [h2fd_pkg::BYTE_W-1:0]     type_byte;
    logic [h2fd_pkg::BYTE_W-1:0]     frame_flags;
    logic [h2fd_pkg::STREAM_W-1:0]   stream_number;
    logic                            frame_end;
    h2fd_pkg::t_err                  error_code;

    modport source (output valid, output kind, output data_byte, output frame_length,
                    output type_byte, output frame_flags, output stream_number,
                    output frame_end, output error_code, input ready);
    modport sink   (input valid, input kind, input data_byte, input frame_length,
                    input type_byte, input frame_flags, input stream_number,
                    input frame_end, input error_code, output ready);
endinterface

[rtl/core/h2fd_cfg_if.sv]
// Configuration write channel.
`timescale 1ns / 1ps

interface h2fd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [h2fd_pkg::CFG_IDX_W-1:0]    index;
    logic [h2fd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/http2_frame_deframer.sv]
// HTTP/2 receive deframer top level: byte decode and two-deep output stage.
//
// i_rx carries one received byte per word; o_res returns exactly one result
// word per byte: its kind, the byte, the header fields as they stand after
// it, the end-of-frame mark and the error code. i_cfg writes the registers:
// index 0 expect_preface (bit 0), index 1 max_frame_size; other indexes are
// ignored. i_cfg is always ready; write it only while the block is idle.
// Each byte's result is registered. Throughput is one byte per cycle
// while ready, set by the single decode stage between the parser state
// and the output register. The output stage holds a main and a skid word,
// so a byte is still taken in the cycle the receiver first stalls; i_rx
// drops ready only while both words wait. No result is lost under stall.
// Synchronous active-low reset clears the output stage and returns the
// parser to header byte 0 with max_frame_size 16384, preface check off.
// After the first error every further byte yields a halted word carrying
// the held error code, until reset.
`timescale 1ns / 1ps
`include "http2_frame_deframer_defines.svh"

module http2_frame_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    h2fd_byte_if.sink         i_rx,
    h2fd_cfg_if.sink          i_cfg,
    h2fd_result_if.source     o_res
);

    logic               rx_accept;
    logic               out_take;
    logic               halted;
    h2fd_pkg::t_result  step_res;
    h2fd_pkg::t_result  r_main;
    h2fd_pkg::t_result  r_skid;
    logic               r_main_v;
    logic               r_skid_v;

    assign i_rx.ready  = !r_skid_v;
    assign i_cfg.ready = 1'b1;
    assign rx_accept   = i_rx.valid && !r_skid_v;
    assign out_take    = r_main_v && o_res.ready;

    h2fd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_result    (step_res),
        .o_halted    (halted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (rx_accept) begin
            if (!r_main_v || out_take) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_take) begin
            r_main_v <= r_skid_v;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            if (!r_main_v || out_take) begin
                r_main <= step_res;
            end else begin
                r_skid <= step_res;
            end
        end else if (out_take && r_skid_v) begin
            r_main <= r_skid;
        end
    end

    assign o_res.valid         = r_main_v;
    assign o_res.kind          = r_main.kind;
    assign o_res.data_byte     = r_main.data_byte;
    assign o_res.frame_length  = r_main.frame_length;
    assign o_res.type_byte     = r_main.type_byte;
    assign o_res.frame_flags   = r_main.frame_flags;
    assign o_res.stream_number = r_main.stream_number;
    assign o_res.frame_end     = r_main.frame_end;
    assign o_res.error_code    = r_main.error_code;

    `H2FD_ASSERT_NOW(a_skid_behind_main, r_skid_v, r_main_v, "skid word without main word")
    `H2FD_ASSERT_NEXT(a_error_halts, rx_accept && step_res.kind == h2fd_pkg::KIND_ERROR,
                      halted, "error word did not halt the parser")
    `H2FD_ASSERT_NOW(a_err_code_kind,
                     o_res.valid && (o_res.kind == h2fd_pkg::KIND_ERROR ||
                                     o_res.kind == h2fd_pkg::KIND_HALTED),
                     o_res.error_code != h2fd_pkg::ERR_NONE, "error word with no code")
    `H2FD_ASSERT_NOW(a_end_kind, o_res.valid && o_res.frame_end,
                     o_res.kind == h2fd_pkg::KIND_HDR_DONE ||
                     o_res.kind == h2fd_pkg::KIND_PAYLOAD, "frame end on wrong kind")

endmodule

[rtl/core/h2fd_parser.sv]
// Deframer state and per-byte decode: preface, header assembly, checks, payload count.
`timescale 1ns / 1ps

module h2fd_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [h2fd_pkg::BYTE_W-1:0]         i_rx_byte,
    input  logic                                i_cfg_we,
    input  logic [h2fd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [h2fd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output h2fd_pkg::t_result                   o_result,
    output logic                                o_halted
);

    logic [h2fd_pkg::PHASE_W-1:0]   r_phase,  n_phase;
    logic [h2fd_pkg::LEN_W-1:0]     r_length, n_length;
    logic [h2fd_pkg::BYTE_W-1:0]    r_type,   n_type;
    logic [h2fd_pkg::BYTE_W-1:0]    r_flags,  n_flags;
    logic [h2fd_pkg::STREAM_W-1:0]  r_stream, n_stream;
    logic [h2fd_pkg::LEN_W-1:0]     r_left,   n_left;
    logic                           r_first,  n_first;
    logic [h2fd_pkg::STREAM_W-1:0]  r_cont,   n_cont;
    h2fd_pkg::t_err                 r_held,   n_held;
    logic                           r_fresh;
    logic [h2fd_pkg::LEN_W-1:0]     r_max;

    logic [h2fd_pkg::PHASE_W-1:0]   hdr_off;
    logic [3:0]                     hdr_idx;
    logic [h2fd_pkg::BYTE_W-1:0]    b;
    h2fd_pkg::t_kind                kind;
    h2fd_pkg::t_err                 err;
    logic                           fend;

    assign b        = i_rx_byte;
    assign hdr_off  = r_phase - h2fd_pkg::PH_HDR0;
    assign hdr_idx  = hdr_off[3:0];
    assign o_halted = (r_phase >= h2fd_pkg::PH_HALT);

    always_comb begin
        n_phase  = r_phase;
        n_length = r_length;
        n_type   = r_type;
        n_flags  = r_flags;
        n_stream = r_stream;
        n_left   = r_left;
        n_first  = r_first;
        n_cont   = r_cont;
        n_held   = r_held;
        kind     = h2fd_pkg::KIND_PREFACE;
        err      = h2fd_pkg::ERR_NONE;
        fend     = 1'b0;

        if (r_phase >= h2fd_pkg::PH_HALT) begin
            kind = h2fd_pkg::KIND_HALTED;
            err  = r_held;
        end else if (r_phase < h2fd_pkg::PH_HDR0) begin
            if (b == h2fd_pkg::preface_byte(r_phase[4:0])) begin
                n_phase = r_phase + 6'd1;
            end else begin
                err = h2fd_pkg::ERR_PREFACE;
            end
        end else if (r_phase < h2fd_pkg::PH_PAYLOAD) begin
            unique case (hdr_idx)
                h2fd_pkg::HDR_LEN_HI:  n_length = {b, 16'h0000};
                h2fd_pkg::HDR_LEN_MID: n_length = {r_length[23:16], b, r_length[7:0]};
                h2fd_pkg::HDR_LEN_LO:  n_length = {r_length[23:8], b};
                h2fd_pkg::HDR_TYPE:    n_type   = b;
                h2fd_pkg::HDR_FLAGS:   n_flags  = b;
                h2fd_pkg::HDR_SID3:
                    n_stream = {b[6:0] & h2fd_pkg::SID_TOP_MASK[6:0], 24'h000000};
                h2fd_pkg::HDR_SID2:    n_stream = {r_stream[30:24], b, r_stream[15:0]};
                h2fd_pkg::HDR_SID1:    n_stream = {r_stream[30:16], b, r_stream[7:0]};
                default:               n_stream = {r_stream[30:8], b};
            endcase
            if (r_phase < h2fd_pkg::PH_HDR_LAST) begin
                kind    = h2fd_pkg::KIND_HDR_BYTE;
                n_phase = r_phase + 6'd1;
            end else begin
                if (r_first && n_type != h2fd_pkg::TYPE_SETTINGS) begin
                    err = h2fd_pkg::ERR_FIRST_NOT_SET;
                end else begin
                    n_first = 1'b0;
                    if (r_cont != '0) begin
                        if (n_type != h2fd_pkg::TYPE_CONT) begin
                            err = h2fd_pkg::ERR_CONT_EXPECT;
                        end else if (r_cont != n_stream) begin
                            err = h2fd_pkg::ERR_CONT_STREAM;
                        end else begin
                            n_cont = n_flags[h2fd_pkg::FLAG_END_HEADERS] ? '0 : n_stream;
                        end
                    end else if (n_type == h2fd_pkg::TYPE_HEADERS) begin
                        n_cont = n_flags[h2fd_pkg::FLAG_END_HEADERS] ? '0 : n_stream;
                    end else if (n_type == h2fd_pkg::TYPE_CONT) begin
                        err = h2fd_pkg::ERR_CONT_UNEXP;
                    end else if (n_type == h2fd_pkg::TYPE_SETTINGS && n_stream != '0) begin
                        err = h2fd_pkg::ERR_SET_STREAM;
                    end
                    if (err == h2fd_pkg::ERR_NONE && n_length != '0 && n_length > r_max) begin
                        err = h2fd_pkg::ERR_TOO_LARGE;
                    end
                end
                if (err == h2fd_pkg::ERR_NONE) begin
                    kind = h2fd_pkg::KIND_HDR_DONE;
                    if (n_length == '0) begin
                        fend    = 1'b1;
                        n_phase = h2fd_pkg::PH_HDR0;
                    end else begin
                        n_left  = n_length;
                        n_phase = h2fd_pkg::PH_PAYLOAD;
                    end
                end
            end
        end else begin
            kind   = h2fd_pkg::KIND_PAYLOAD;
            n_left = r_left - 24'd1;
            if (n_left == '0) begin
                fend    = 1'b1;
                n_phase = h2fd_pkg::PH_HDR0;
            end
        end

        if (err != h2fd_pkg::ERR_NONE && kind != h2fd_pkg::KIND_HALTED) begin
            kind    = h2fd_pkg::KIND_ERROR;
            n_held  = err;
            n_phase = h2fd_pkg::PH_HALT;
        end
    end

    always_comb begin
        o_result.kind          = kind;
        o_result.data_byte     = b;
        o_result.frame_length  = n_length;
        o_result.type_byte     = n_type;
        o_result.frame_flags   = n_flags;
        o_result.stream_number = n_stream;
        o_result.frame_end     = fend;
        o_result.error_code    = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= h2fd_pkg::PH_HDR0;
            r_length <= '0;
            r_type   <= '0;
            r_flags  <= '0;
            r_stream <= '0;
            r_left   <= '0;
            r_first  <= 1'b1;
            r_cont   <= '0;
            r_held   <= h2fd_pkg::ERR_NONE;
            r_fresh  <= 1'b1;
            r_max    <= h2fd_pkg::MAX_FRAME_RESET;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_type   <= n_type;
            r_flags  <= n_flags;
            r_stream <= n_stream;
            r_left   <= n_left;
            r_first  <= n_first;
            r_cont   <= n_cont;
            r_held   <= n_held;
            r_fresh  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == h2fd_pkg::CFG_EXPECT_PREFACE && r_fresh) begin
                r_phase <= i_cfg_data[0] ? h2fd_pkg::PH_PREFACE0 : h2fd_pkg::PH_HDR0;
            end
            if (i_cfg_index == h2fd_pkg::CFG_MAX_FRAME_SIZE) begin
                r_max <= i_cfg_data[h2fd_pkg::LEN_W-1:0];
            end
        end
    end

endmodule
